### rtl/ic_pkg.sv
// shared types and constants for the inversion counter
// no dependencies
package ic_pkg;

  localparam int COUNT_BITS = 19;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic valid;
    logic live;
    logic last;
  } item_ctl_t;

endpackage

### rtl/ic_cell.sv
// one compare cell of the inversion counter chain
// holds one stored key, counts for passing requests, depends on ic_pkg
module ic_cell #(
  parameter int CELL_INDEX = 0,
  parameter int KEY_BITS   = 32,
  parameter int IDX_BITS   = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ic_pkg::item_ctl_t     ctl_in,
  input  logic [KEY_BITS-1:0]   key_in,
  input  logic [IDX_BITS-1:0]   idx_in,
  input  logic [IDX_BITS-1:0]   cnt_in,
  output ic_pkg::item_ctl_t     ctl_out,
  output logic [KEY_BITS-1:0]   key_out,
  output logic [IDX_BITS-1:0]   idx_out,
  output logic [IDX_BITS-1:0]   cnt_out
);

  localparam logic [IDX_BITS-1:0] CELL_IDX = IDX_BITS'(CELL_INDEX);

  logic [KEY_BITS-1:0] stored;
  logic                write_en;
  logic                hit;

  assign write_en = ctl_in.valid & ctl_in.live & (idx_in == CELL_IDX);
  // only cells filled earlier in the sequence take part
  assign hit = ctl_in.valid & ctl_in.live & (idx_in > CELL_IDX) & (stored > key_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    key_out <= key_in;
    idx_out <= idx_in;
    cnt_out <= cnt_in + IDX_BITS'(hit);
    if (write_en) begin
      stored <= key_in;
    end
  end

endmodule

### rtl/ic_acc.sv
// running total and result register at the end of the cell chain
// saturating accumulate of per-request counts, depends on ic_pkg
module ic_acc #(
  parameter int CNT_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ic_pkg::item_ctl_t             ctl,
  input  logic [CNT_BITS-1:0]           cnt,
  input  logic                          overflow,
  input  logic                          result_ready,
  output logic                          result_valid,
  output logic [ic_pkg::COUNT_BITS-1:0] inversion_count,
  output logic                          too_many
);

  logic [ic_pkg::COUNT_BITS-1:0] total;
  logic [ic_pkg::COUNT_BITS:0]   sum;
  logic [ic_pkg::COUNT_BITS-1:0] total_next;

  assign sum = {1'b0, total} + (ic_pkg::COUNT_BITS + 1)'(cnt);
  assign total_next = (sum > {1'b0, ic_pkg::COUNT_MAX}) ? ic_pkg::COUNT_MAX
                                                        : sum[ic_pkg::COUNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      total        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (ctl.valid) begin
        if (ctl.last) begin
          total        <= '0;
          result_valid <= 1'b1;
        end else begin
          total <= total_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid && ctl.last) begin
      inversion_count <= total_next;
      too_many        <= overflow;
    end
  end

endmodule

### rtl/inversion_counter_top.sv
// inversion counter top level: input control, row of compare cells, accumulator
// depends on ic_pkg, ic_cell, ic_acc
//
// Counts pairs i<j of a sequence whose earlier value is strictly greater than the
// later one. Values stream into a row of MAX_ELEMENTS compare cells at one request
// per cycle while not busy; each request walks the row one cell per cycle, picks
// up a count from every earlier value it passes and is stored in the cell matching
// its position. The result is registered in the accumulator once the request with
// last_element has passed through the whole cell row; the next sequence is taken
// once that result has been accepted. Values beyond MAX_ELEMENTS are dropped and
// flagged in too_many; the count saturates at the top of its 19-bit range.
module inversion_counter_top #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic signed [VALUE_BITS-1:0]  value,
  input  logic                          last_element,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [ic_pkg::COUNT_BITS-1:0] inversion_count,
  output logic                          too_many
);

  localparam int IDX_BITS  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int FILL_BITS = $clog2(MAX_ELEMENTS + 1);
  localparam logic [FILL_BITS-1:0]  MAX_FILL  = FILL_BITS'(MAX_ELEMENTS);
  localparam logic [VALUE_BITS-1:0] SIGN_FLIP = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [FILL_BITS-1:0] fill;
  logic                 overflow_seen;
  logic                 busy;
  logic                 accept;
  logic                 live_in;

  ic_pkg::item_ctl_t    ctl_s [MAX_ELEMENTS+1];
  logic [VALUE_BITS-1:0] key_s [MAX_ELEMENTS];
  logic [IDX_BITS-1:0]  idx_s [MAX_ELEMENTS];
  logic [IDX_BITS-1:0]  cnt_s [MAX_ELEMENTS+1];

  assign item_ready = ~busy;
  assign accept     = item_valid & item_ready;
  assign live_in    = fill < MAX_FILL;

  assign ctl_s[0].valid = accept;
  assign ctl_s[0].live  = live_in;
  assign ctl_s[0].last  = last_element;
  assign key_s[0]       = $unsigned(value) ^ SIGN_FLIP;
  assign idx_s[0]       = fill[IDX_BITS-1:0];
  assign cnt_s[0]       = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      overflow_seen <= 1'b0;
      busy          <= 1'b0;
    end else begin
      if (accept) begin
        if (last_element) begin
          fill <= '0;
          busy <= 1'b1;
        end else if (live_in) begin
          fill <= fill + FILL_BITS'(1);
        end
        if (!live_in) begin
          overflow_seen <= 1'b1;
        end
      end
      if (result_valid && result_ready) begin
        busy          <= 1'b0;
        overflow_seen <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    if (i < MAX_ELEMENTS - 1) begin : g_mid
      ic_cell #(
        .CELL_INDEX(i),
        .KEY_BITS  (VALUE_BITS),
        .IDX_BITS  (IDX_BITS)
      ) u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctl_in (ctl_s[i]),
        .key_in (key_s[i]),
        .idx_in (idx_s[i]),
        .cnt_in (cnt_s[i]),
        .ctl_out(ctl_s[i+1]),
        .key_out(key_s[i+1]),
        .idx_out(idx_s[i+1]),
        .cnt_out(cnt_s[i+1])
      );
    end else begin : g_end
      ic_cell #(
        .CELL_INDEX(i),
        .KEY_BITS  (VALUE_BITS),
        .IDX_BITS  (IDX_BITS)
      ) u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctl_in (ctl_s[i]),
        .key_in (key_s[i]),
        .idx_in (idx_s[i]),
        .cnt_in (cnt_s[i]),
        .ctl_out(ctl_s[i+1]),
        .key_out(),
        .idx_out(),
        .cnt_out(cnt_s[i+1])
      );
    end
  end

  ic_acc #(
    .CNT_BITS(IDX_BITS)
  ) u_acc (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl_s[MAX_ELEMENTS]),
    .cnt            (cnt_s[MAX_ELEMENTS]),
    .overflow       (overflow_seen),
    .result_ready   (result_ready),
    .result_valid   (result_valid),
    .inversion_count(inversion_count),
    .too_many       (too_many)
  );

`ifndef SYNTHESIS
  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result shown with no sequence pending");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= MAX_FILL)
    else $error("fill count beyond cell row");

  a_single_marker: assert property (@(posedge clk) disable iff (rst)
    (ctl_s[MAX_ELEMENTS].valid && ctl_s[MAX_ELEMENTS].last) |-> !result_valid)
    else $error("end of sequence reached tail while result still pending");

  a_last_starts_drain: assert property (@(posedge clk) disable iff (rst)
    (accept && last_element) |=> (busy && fill == '0))
    else $error("last request did not close the sequence");
`endif

endmodule
